>>> rtl/qwsb_pkg.sv
// shared types and constants for the quorum weighted signal blend
package qwsb_pkg;

	localparam int unsigned SLOTS = 4;
	localparam int unsigned NVAL = 5;
	localparam int unsigned TS_W = 63;
	// sum of up to four 16x16 products: 34 bits, plus sign guard
	localparam int unsigned ACC_W = 36;
	// total weight: four 16-bit weights
	localparam int unsigned TOT_W = 18;
	localparam int unsigned QUO_W = ACC_W;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_TICK  = 2'd1,
		OP_FORCE = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_MIN_SRC  = 3'd1,
		REG_STALE    = 3'd2,
		REG_CLR_PEND = 3'd3,
		REG_ENABLE   = 3'd4,
		REG_WEIGHTS  = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_EQUAL  = 2'd0,
		MODE_CONF   = 2'd1,
		MODE_CUSTOM = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic       load;       // capture input beat and apply op
		logic       acc_clear;
		logic       acc_step;   // accumulate slot acc_slot
		logic [1:0] acc_slot;
		logic       div_start;  // start division of field div_field
		logic [2:0] div_field;
		logic       out_load;
		logic       out_cause;
		logic       clr_pending;
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic      quorum;      // push reached quorum (valid after load)
		logic      is_push_ok;  // op was a push from a live slot
		logic      is_force;
		logic      div_done;
		logic      clr_en;
	} sts_t;

endpackage

>>> rtl/qwsb_div.sv
// signed restoring divider, one quotient bit per cycle
module qwsb_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [qwsb_pkg::ACC_W-1:0]  dividend,
	input  logic        [qwsb_pkg::TOT_W-1:0]  divisor,
	output logic                               done,
	output logic signed [15:0]                 quotient
);
	localparam int unsigned W = qwsb_pkg::ACC_W;
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0] rem_q, quo_q;
	logic [qwsb_pkg::TOT_W-1:0] dsr_q;
	logic neg_q, busy_q;
	logic [CW-1:0] cnt_q;
	logic [W:0] trial;
	logic [W-1:0] mag;
	logic signed [W:0] sq;

	assign trial = {rem_q, quo_q[W-1]} - {{(W + 1 - qwsb_pkg::TOT_W){1'b0}}, dsr_q};

	// iterate over quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[W-1];
			quo_q <= dividend[W-1] ? W'(-dividend) : dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	// sign restore and saturation
	always_comb begin
		mag = quo_q;
		sq = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		if (sq > 32767) quotient = 16'sh7fff;
		else if (sq < -32768) quotient = 16'sh8000;
		else quotient = sq[15:0];
	end

`ifndef NO_ASSERTIONS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("busy at done");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("start while busy");
`endif
endmodule

>>> rtl/qwsb_datapath.sv
// slot storage, weighting, accumulators, divider and output register
module qwsb_datapath #(
	parameter int unsigned NUM_SOURCES = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [2:0]                   cfg_index,
	input  logic [63:0]                  cfg_data,
	input  logic [1:0]                   operation,
	input  logic [1:0]                   source_index,
	input  logic signed [15:0]           bias,
	input  logic signed [15:0]           volatility,
	input  logic signed [15:0]           confidence,
	input  logic signed [15:0]           spread,
	input  logic signed [15:0]           quality,
	input  logic [qwsb_pkg::TS_W-1:0]    timestamp,
	input  qwsb_pkg::cmd_t               cmd,
	output qwsb_pkg::sts_t               sts,
	output logic signed [15:0]           blend_bias,
	output logic signed [15:0]           blend_volatility,
	output logic signed [15:0]           blend_confidence,
	output logic signed [15:0]           blend_spread,
	output logic signed [15:0]           blend_quality,
	output logic [qwsb_pkg::TS_W-1:0]    blend_timestamp,
	output logic                         cause,
	output logic [2:0]                   contributors
);
	localparam int unsigned S = qwsb_pkg::SLOTS;
	localparam int unsigned AW = qwsb_pkg::ACC_W;
	localparam int unsigned TW = qwsb_pkg::TOT_W;

	// configuration registers
	logic [1:0]  mode_q;
	logic [2:0]  min_src_q;
	logic [15:0] stale_q;
	logic        clr_pend_q;
	logic [3:0]  en_q;
	logic [63:0] wts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
			min_src_q <= 3'd1;
			stale_q <= '0;
			clr_pend_q <= 1'b1;
			en_q <= '0;
			wts_q <= 64'h1000_1000_1000_1000;
		end else if (cfg_valid) begin
			case (cfg_index)
				qwsb_pkg::REG_MODE:     mode_q <= cfg_data[1:0];
				qwsb_pkg::REG_MIN_SRC:  min_src_q <= cfg_data[2:0];
				qwsb_pkg::REG_STALE:    stale_q <= cfg_data[15:0];
				qwsb_pkg::REG_CLR_PEND: clr_pend_q <= cfg_data[0];
				qwsb_pkg::REG_ENABLE:   en_q <= cfg_data[3:0];
				qwsb_pkg::REG_WEIGHTS:  wts_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// slot state
	logic signed [15:0] val_q [S][qwsb_pkg::NVAL];
	logic [qwsb_pkg::TS_W-1:0] ts_q [S];
	logic [S-1:0] pend_q, pushed_q;
	logic [15:0] age_q [S];
	logic [S-1:0] live, fresh;

	always_comb begin
		for (int i = 0; i < S; i++) begin
			live[i] = (i < NUM_SOURCES) && en_q[i];
			fresh[i] = (stale_q == '0) || (pushed_q[i] && age_q[i] <= stale_q);
		end
	end

	logic push_ok;
	assign push_ok = (operation == qwsb_pkg::OP_PUSH) && live[source_index];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pushed_q <= '0;
			for (int i = 0; i < S; i++) begin
				age_q[i] <= '0;
				ts_q[i] <= '0;
				for (int k = 0; k < qwsb_pkg::NVAL; k++) val_q[i][k] <= '0;
			end
		end else if (cmd.load) begin
			case (operation)
				qwsb_pkg::OP_PUSH: begin
					if (push_ok) begin
						val_q[source_index][0] <= bias;
						val_q[source_index][1] <= volatility;
						val_q[source_index][2] <= confidence;
						val_q[source_index][3] <= spread;
						val_q[source_index][4] <= quality;
						ts_q[source_index] <= timestamp;
						pend_q[source_index] <= 1'b1;
						pushed_q[source_index] <= 1'b1;
						age_q[source_index] <= '0;
					end
				end
				qwsb_pkg::OP_TICK: begin
					for (int i = 0; i < S; i++)
						if (age_q[i] != 16'hffff) age_q[i] <= age_q[i] + 1'b1;
				end
				qwsb_pkg::OP_CLEAR: begin
					pend_q <= '0;
					pushed_q <= '0;
					for (int i = 0; i < S; i++) begin
						age_q[i] <= '0;
						ts_q[i] <= '0;
						for (int k = 0; k < qwsb_pkg::NVAL; k++) val_q[i][k] <= '0;
					end
				end
				default: ;
			endcase
		end else if (cmd.clr_pending) begin
			pend_q <= '0;
		end
	end

	// status, taken after the push is stored
	logic [2:0] pcount;
	always_comb begin
		pcount = '0;
		for (int i = 0; i < S; i++)
			pcount = pcount + 3'(live[i] && pend_q[i] && fresh[i]);
	end

	logic push_ok_q, force_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_ok_q <= 1'b0;
			force_q <= 1'b0;
		end else if (cmd.load) begin
			push_ok_q <= push_ok;
			force_q <= (operation == qwsb_pkg::OP_FORCE);
		end
	end

	// slot weight for the accumulate step
	logic signed [15:0] sv [qwsb_pkg::NVAL];
	logic [15:0] w;
	logic contrib;
	always_comb begin
		for (int k = 0; k < qwsb_pkg::NVAL; k++) sv[k] = val_q[cmd.acc_slot][k];
		contrib = live[cmd.acc_slot] && pushed_q[cmd.acc_slot] && fresh[cmd.acc_slot];
		case (mode_q)
			qwsb_pkg::MODE_CONF:   w = (sv[2] < 16'sd1) ? 16'd1 : sv[2];
			qwsb_pkg::MODE_CUSTOM: w = wts_q[16*cmd.acc_slot +: 16];
			default:               w = 16'd1;
		endcase
	end

	// accumulators
	logic signed [AW-1:0] acc_q [qwsb_pkg::NVAL];
	logic [TW-1:0] tot_q;
	logic [qwsb_pkg::TS_W-1:0] tsmax_q;
	logic [2:0] cnt_q;
	logic signed [32:0] prod [qwsb_pkg::NVAL];

	always_comb
		for (int k = 0; k < qwsb_pkg::NVAL; k++)
			prod[k] = $signed({1'b0, w}) * sv[k];

	always_ff @(posedge clk) begin
		if (cmd.acc_clear) begin
			for (int k = 0; k < qwsb_pkg::NVAL; k++) acc_q[k] <= '0;
			tot_q <= '0;
			tsmax_q <= '0;
			cnt_q <= '0;
		end else if (cmd.acc_step && contrib) begin
			for (int k = 0; k < qwsb_pkg::NVAL; k++)
				acc_q[k] <= acc_q[k] + AW'(prod[k]);
			tot_q <= tot_q + TW'(w);
			cnt_q <= cnt_q + 3'd1;
			if (ts_q[cmd.acc_slot] > tsmax_q) tsmax_q <= ts_q[cmd.acc_slot];
		end
	end

	// shared divider
	logic div_done;
	logic signed [15:0] quo;
	qwsb_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(acc_q[cmd.div_field]), .divisor(tot_q),
		.done(div_done), .quotient(quo)
	);

	logic signed [15:0] res_q [qwsb_pkg::NVAL];
	always_ff @(posedge clk) begin
		if (div_done) res_q[cmd.div_field] <= (tot_q == '0) ? 16'sd0 : quo;
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			blend_bias <= res_q[0];
			blend_volatility <= res_q[1];
			blend_confidence <= res_q[2];
			blend_spread <= res_q[3];
			blend_quality <= res_q[4];
			blend_timestamp <= tsmax_q;
			cause <= cmd.out_cause;
			contributors <= cnt_q;
		end
	end

	assign sts.quorum = pcount >= min_src_q;
	assign sts.is_push_ok = push_ok_q;
	assign sts.is_force = force_q;
	assign sts.div_done = div_done;
	assign sts.clr_en = clr_pend_q;
endmodule

>>> rtl/qwsb_ctrl.sv
// sequencing state machine for accept, scan, divide and output
module qwsb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  qwsb_pkg::sts_t   sts,
	output qwsb_pkg::cmd_t   cmd
);
	qwsb_pkg::state_t st_q, st_d;
	logic [2:0] idx_q, idx_d;
	logic cause_q, cause_d, ovld_q, ovld_d;
	logic eval_q;

	// next state
	always_comb begin
		st_d = st_q;
		idx_d = idx_q;
		cause_d = cause_q;
		ovld_d = ovld_q;
		if (ovld_q && out_ready) ovld_d = 1'b0;
		case (st_q)
			qwsb_pkg::ST_IDLE: begin
				if (eval_q) begin
					if ((sts.is_push_ok && sts.quorum) || sts.is_force) begin
						st_d = qwsb_pkg::ST_ACCUM;
						idx_d = '0;
						cause_d = sts.is_force;
					end
				end
			end
			qwsb_pkg::ST_ACCUM: begin
				idx_d = idx_q + 3'd1;
				if (idx_q == 3'd3) begin
					st_d = qwsb_pkg::ST_DIV_START;
					idx_d = '0;
				end
			end
			qwsb_pkg::ST_DIV_START: st_d = qwsb_pkg::ST_DIV_WAIT;
			qwsb_pkg::ST_DIV_WAIT: begin
				if (sts.div_done) begin
					idx_d = idx_q + 3'd1;
					st_d = (idx_q == 3'd4) ? qwsb_pkg::ST_OUT : qwsb_pkg::ST_DIV_START;
				end
			end
			qwsb_pkg::ST_OUT: begin
				if (!ovld_q || out_ready) begin
					st_d = qwsb_pkg::ST_IDLE;
					ovld_d = 1'b1;
				end
			end
			default: st_d = qwsb_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = (st_q == qwsb_pkg::ST_IDLE) && !eval_q;
		cmd.load = in_valid && in_ready;
		cmd.acc_clear = (st_q == qwsb_pkg::ST_IDLE);
		cmd.acc_step = (st_q == qwsb_pkg::ST_ACCUM);
		cmd.acc_slot = idx_q[1:0];
		cmd.div_start = (st_q == qwsb_pkg::ST_DIV_START);
		cmd.div_field = idx_q;
		cmd.out_load = (st_q == qwsb_pkg::ST_OUT) && (!ovld_q || out_ready);
		cmd.out_cause = cause_q;
		cmd.clr_pending = cmd.out_load && !cause_q && sts.clr_en;
		out_valid = ovld_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= qwsb_pkg::ST_IDLE;
			idx_q <= '0;
			cause_q <= 1'b0;
			ovld_q <= 1'b0;
			eval_q <= 1'b0;
		end else begin
			st_q <= st_d;
			idx_q <= idx_d;
			cause_q <= cause_d;
			ovld_q <= ovld_d;
			eval_q <= cmd.load;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != qwsb_pkg::ST_IDLE) |-> !in_ready) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ovld_q && !out_ready) |=> ovld_q) else $error("result dropped");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == qwsb_pkg::ST_DIV_START) |=> (st_q == qwsb_pkg::ST_DIV_WAIT))
		else $error("divider sequence");
`endif
endmodule

>>> rtl/quorum_weighted_signal_blend_top.sv
// An emitting push or force passes a decode step, one accumulate step per slot for all four
// slots, five divisions on the shared divider and one load of the output register.
// A new item waits until the last is done; ticks, clears and silent pushes end after decode.
// A finished result waits in the output register while the next item is taken.
// Reset arst_n clears registers to defaults and all slots immediately; no sweep.
module quorum_weighted_signal_blend_top #(
	parameter int unsigned NUM_SOURCES = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [63:0]               cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                operation,
	input  logic [1:0]                source_index,
	input  logic signed [15:0]        bias,
	input  logic signed [15:0]        volatility,
	input  logic signed [15:0]        confidence,
	input  logic signed [15:0]        spread,
	input  logic signed [15:0]        quality,
	input  logic [62:0]               timestamp,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [15:0]        blend_bias,
	output logic signed [15:0]        blend_volatility,
	output logic signed [15:0]        blend_confidence,
	output logic signed [15:0]        blend_spread,
	output logic signed [15:0]        blend_quality,
	output logic [62:0]               blend_timestamp,
	output logic                      cause,
	output logic [2:0]                contributors
);
	qwsb_pkg::cmd_t cmd;
	qwsb_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	qwsb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	qwsb_datapath #(.NUM_SOURCES(NUM_SOURCES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .operation(operation), .source_index(source_index),
		.bias(bias), .volatility(volatility), .confidence(confidence),
		.spread(spread), .quality(quality), .timestamp(timestamp),
		.cmd(cmd), .sts(sts),
		.blend_bias(blend_bias), .blend_volatility(blend_volatility),
		.blend_confidence(blend_confidence), .blend_spread(blend_spread),
		.blend_quality(blend_quality), .blend_timestamp(blend_timestamp),
		.cause(cause), .contributors(contributors)
	);
endmodule

>>> tb/quorum_weighted_signal_blend_top_test.sv
// testbench for the quorum weighted signal blend: directed and random beats checked against a local predictor
`timescale 1ns / 100ps

module quorum_weighted_signal_blend_top_test;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 250;

	typedef struct packed {
		logic signed [15:0] bias;
		logic signed [15:0] volatility;
		logic signed [15:0] confidence;
		logic signed [15:0] spread;
		logic signed [15:0] quality;
		logic [62:0]        timestamp;
		logic               cause;
		logic [2:0]         contributors;
	} blend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] operation = '0;
	logic [1:0] source_index = '0;
	logic signed [15:0] bias = '0, volatility = '0, confidence = '0, spread = '0, quality = '0;
	logic [62:0] timestamp = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] blend_bias, blend_volatility, blend_confidence, blend_spread;
	logic signed [15:0] blend_quality;
	logic [62:0] blend_timestamp;
	logic cause;
	logic [2:0] contributors;

	quorum_weighted_signal_blend_top u_dut (.*);

	// predictor copy of registers and slot state
	logic [1:0] mode_q;
	logic [2:0] quorum_q;
	logic [15:0] stale_q;
	logic clr_pend_q;
	logic [3:0] enable_q;
	logic [63:0] weights_q;
	logic signed [15:0] slot_val [4][5];
	logic [62:0] slot_ts [4];
	logic slot_pending [4];
	logic slot_pushed [4];
	logic [15:0] slot_age [4];

	blend_t expected_blends [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit recv_hold = 0;
	int idle_cycles = 0;

	initial forever #4 clk = ~clk;

	function automatic bit slot_fresh(int i);
		if (stale_q == 0) return 1;
		if (!slot_pushed[i]) return 0;
		return slot_age[i] <= stale_q;
	endfunction

	function automatic blend_t compute_blend(logic c);
		blend_t r;
		longint sums [5];
		longint total, w, q;
		logic [62:0] ts;
		int n;
		total = 0; ts = '0; n = 0;
		for (int k = 0; k < 5; k++) sums[k] = 0;
		for (int i = 0; i < 4; i++) begin
			if (!enable_q[i] || !slot_pushed[i] || !slot_fresh(i)) continue;
			if (mode_q == qwsb_pkg::MODE_CONF) begin
				w = slot_val[i][2];
				if (w < 1) w = 1;
			end else if (mode_q == qwsb_pkg::MODE_CUSTOM) begin
				w = longint'(weights_q[16*i +: 16]);
			end else begin
				w = 1;
			end
			for (int k = 0; k < 5; k++) sums[k] += w * longint'(slot_val[i][k]);
			total += w;
			n++;
			if (slot_ts[i] > ts) ts = slot_ts[i];
		end
		for (int k = 0; k < 5; k++) begin
			q = 0;
			if (total > 0) begin
				q = sums[k] / total;
				if (q > 32767) q = 32767;
				if (q < -32768) q = -32768;
			end
			case (k)
				0: r.bias = q[15:0];
				1: r.volatility = q[15:0];
				2: r.confidence = q[15:0];
				3: r.spread = q[15:0];
				default: r.quality = q[15:0];
			endcase
		end
		r.timestamp = ts;
		r.cause = c;
		r.contributors = n[2:0];
		return r;
	endfunction

	function automatic void clear_slots();
		for (int i = 0; i < 4; i++) begin
			for (int k = 0; k < 5; k++) slot_val[i][k] = '0;
			slot_ts[i] = '0;
			slot_pending[i] = 0;
			slot_pushed[i] = 0;
			slot_age[i] = '0;
		end
	endfunction

	// queue one expected result beat
	function automatic void expect_blend(blend_t b);
		expected_blends = {expected_blends, b};
	endfunction

	// apply one item to the predictor
	function automatic void predict_item(qwsb_pkg::op_t op, logic [1:0] s,
			logic signed [15:0] v [5], logic [62:0] ts);
		int cnt;
		case (op)
			qwsb_pkg::OP_PUSH: begin
				if (enable_q[s]) begin
					for (int k = 0; k < 5; k++) slot_val[s][k] = v[k];
					slot_ts[s] = ts;
					slot_pending[s] = 1;
					slot_pushed[s] = 1;
					slot_age[s] = '0;
					cnt = 0;
					for (int i = 0; i < 4; i++)
						if (enable_q[i] && slot_pending[i] && slot_fresh(i)) cnt++;
					if (cnt >= quorum_q) begin
						expect_blend(compute_blend(1'b0));
						if (clr_pend_q) for (int i = 0; i < 4; i++) slot_pending[i] = 0;
					end
				end
			end
			qwsb_pkg::OP_TICK:
				for (int i = 0; i < 4; i++) if (slot_age[i] != 16'hFFFF) slot_age[i]++;
			qwsb_pkg::OP_FORCE: expect_blend(compute_blend(1'b1));
			default: clear_slots();
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// wait until every expected beat has come and the input is idle
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_blends.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(qwsb_pkg::reg_idx_t idx, logic [63:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			qwsb_pkg::REG_MODE: mode_q = data[1:0];
			qwsb_pkg::REG_MIN_SRC: quorum_q = data[2:0];
			qwsb_pkg::REG_STALE: stale_q = data[15:0];
			qwsb_pkg::REG_CLR_PEND: clr_pend_q = data[0];
			qwsb_pkg::REG_ENABLE: enable_q = data[3:0];
			default: weights_q = data;
		endcase
	endtask

	// send one beat, with random idle before it; valid drops in the idle loop or in drain
	task automatic send_item(qwsb_pkg::op_t op, logic [1:0] s, logic signed [15:0] v [5],
			logic [62:0] ts);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		source_index <= s;
		bias <= v[0];
		volatility <= v[1];
		confidence <= v[2];
		spread <= v[3];
		quality <= v[4];
		timestamp <= ts;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_item(op, s, v, ts);
	endtask

	function automatic logic signed [15:0] rand_value();
		case ($urandom_range(5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 8192));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random(qwsb_pkg::op_t op, logic [1:0] s);
		logic signed [15:0] v [5];
		logic [62:0] ts;
		for (int k = 0; k < 5; k++) v[k] = rand_value();
		ts = 63'({$urandom, $urandom});
		if ($urandom_range(7) == 0) ts = {63{1'b1}};
		send_item(op, s, v, ts);
	endtask

	// receiver: random stall plus long hold-off when asked
	always @(posedge clk) begin
		out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		blend_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_blends.size() == 0) begin
				report_mismatch("unexpected beat", {61'd0, contributors}, 64'd0);
			end else begin
				want = expected_blends.pop_front();
				if (blend_bias !== want.bias)
					report_mismatch("bias", 64'(blend_bias), 64'(want.bias));
				if (blend_volatility !== want.volatility)
					report_mismatch("volatility", 64'(blend_volatility), 64'(want.volatility));
				if (blend_confidence !== want.confidence)
					report_mismatch("confidence", 64'(blend_confidence), 64'(want.confidence));
				if (blend_spread !== want.spread)
					report_mismatch("spread", 64'(blend_spread), 64'(want.spread));
				if (blend_quality !== want.quality)
					report_mismatch("quality", 64'(blend_quality), 64'(want.quality));
				if (blend_timestamp !== want.timestamp)
					report_mismatch("timestamp", 64'(blend_timestamp), 64'(want.timestamp));
				if (cause !== want.cause) report_mismatch("cause", 64'(cause), 64'(want.cause));
				if (contributors !== want.contributors)
					report_mismatch("contributors", 64'(contributors), 64'(want.contributors));
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic test_directed();
		logic signed [15:0] v [5];
		write_reg(qwsb_pkg::REG_ENABLE, 64'hF);
		write_reg(qwsb_pkg::REG_MIN_SRC, 64'd0);
		// extremes of every field, zero quorum emits on every push
		for (int k = 0; k < 5; k++) v[k] = 16'sh7FFF;
		send_item(qwsb_pkg::OP_PUSH, 2'd0, v, {63{1'b1}});
		for (int k = 0; k < 5; k++) v[k] = 16'sh8000;
		send_item(qwsb_pkg::OP_PUSH, 2'd1, v, 63'd0);
		for (int k = 0; k < 5; k++) v[k] = 16'sh0000;
		send_item(qwsb_pkg::OP_PUSH, 2'd2, v, 63'd5);
		for (int k = 0; k < 5; k++) v[k] = -16'sd1;
		send_item(qwsb_pkg::OP_PUSH, 2'd3, v, 63'd7);
		send_item(qwsb_pkg::OP_FORCE, 2'd0, v, 63'd0);
		send_item(qwsb_pkg::OP_TICK, 2'd0, v, 63'd0);
		drain();
		// confidence weights with a big positive weight
		write_reg(qwsb_pkg::REG_MODE, 64'(qwsb_pkg::MODE_CONF));
		send_item(qwsb_pkg::OP_FORCE, 2'd0, v, 63'd0);
		// custom weights, max and zero
		write_reg(qwsb_pkg::REG_MODE, 64'(qwsb_pkg::MODE_CUSTOM));
		write_reg(qwsb_pkg::REG_WEIGHTS, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(qwsb_pkg::OP_FORCE, 2'd0, v, 63'd0);
		write_reg(qwsb_pkg::REG_WEIGHTS, 64'd0);
		send_item(qwsb_pkg::OP_FORCE, 2'd0, v, 63'd0);
		// unused mode falls back to equal weights
		drain();
		write_reg(qwsb_pkg::REG_MODE, 64'd3);
		send_item(qwsb_pkg::OP_FORCE, 2'd0, v, 63'd0);
		// clear, then force with nothing contributing
		send_item(qwsb_pkg::OP_CLEAR, 2'd0, v, 63'd0);
		send_item(qwsb_pkg::OP_FORCE, 2'd0, v, 63'd0);
		drain();
		// quorum above enabled count, disabled slot push
		write_reg(qwsb_pkg::REG_ENABLE, 64'h3);
		write_reg(qwsb_pkg::REG_MIN_SRC, 64'd4);
		write_reg(qwsb_pkg::REG_STALE, 64'd1);
		send_random(qwsb_pkg::OP_PUSH, 2'd0);
		send_random(qwsb_pkg::OP_PUSH, 2'd1);
		send_random(qwsb_pkg::OP_PUSH, 2'd3);
		send_item(qwsb_pkg::OP_TICK, 2'd0, v, 63'd0);
		send_item(qwsb_pkg::OP_TICK, 2'd0, v, 63'd0);
		send_item(qwsb_pkg::OP_FORCE, 2'd0, v, 63'd0);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 60) send_random(qwsb_pkg::OP_PUSH, 2'($urandom_range(3)));
			else if (r < 80) send_random(qwsb_pkg::OP_TICK, 2'($urandom_range(3)));
			else if (r < 96) send_random(qwsb_pkg::OP_FORCE, 2'($urandom_range(3)));
			else send_random(qwsb_pkg::OP_CLEAR, 2'($urandom_range(3)));
		end
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_config();
		write_reg(qwsb_pkg::REG_MODE, 64'($urandom_range(3)));
		write_reg(qwsb_pkg::REG_MIN_SRC, 64'($urandom_range(7)));
		write_reg(qwsb_pkg::REG_STALE, ($urandom_range(2) == 0) ? 64'd0 :
			($urandom_range(3) == 0 ? 64'hFFFF : 64'($urandom_range(1, 6))));
		write_reg(qwsb_pkg::REG_CLR_PEND, 64'($urandom_range(1)));
		write_reg(qwsb_pkg::REG_ENABLE,
			($urandom_range(3) == 0) ? 64'($urandom_range(15)) : 64'hF);
		write_reg(qwsb_pkg::REG_WEIGHTS, {$urandom, $urandom});
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 52 : 0;
			recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 20 : 0;
			for (int c = 0; c < 4; c++) begin
				random_config();
				random_phase(30);
			end
		end
		send_idle_pct = 0;
		recv_idle_pct = 0;
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		write_reg(qwsb_pkg::REG_ENABLE, 64'hF);
		write_reg(qwsb_pkg::REG_MIN_SRC, 64'd0);
		fork
			begin
				recv_hold = 1;
				repeat (600) @(posedge clk);
				recv_hold = 0;
			end
			for (int n = 0; n < 8; n++)
				send_random(qwsb_pkg::OP_PUSH, 2'($urandom_range(3)));
		join
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		mode_q = qwsb_pkg::MODE_EQUAL;
		quorum_q = 3'd1;
		stale_q = '0;
		clr_pend_q = 1'b1;
		enable_q = '0;
		weights_q = 64'h1000100010001000;
		clear_slots();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_blends.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
